// ===== rtl/snfcs_pkg.sv =====
package snfcs_pkg;

    localparam int PAGE_BYTES   = 256;
    localparam int PAGE_BITS    = $clog2(PAGE_BYTES);
    localparam int ADDRESS_BITS = 24;
    localparam int QDEPTH       = 4;
    localparam int QPTR_BITS    = $clog2(QDEPTH);

    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_RDID  = 8'h9F;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_SE    = 8'h20;
    localparam logic [7:0] CMD_PP    = 8'h02;
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef enum logic [2:0] {
        ACT_PROBE = 3'd0,
        ACT_READ  = 3'd1,
        ACT_ERASE = 3'd2,
        ACT_WRITE = 3'd3,
        ACT_BYTE  = 3'd4,
        ACT_DATA  = 3'd5,
        ACT_TICK  = 3'd6,
        ACT_NONE  = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        OP_PROBE = 2'd0,
        OP_READ  = 2'd1,
        OP_ERASE = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_SPI   = 3'd0,
        K_CS    = 3'd1,
        K_REQ   = 3'd2,
        K_RBYTE = 3'd3,
        K_DONE  = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ID_CMD, PH_ID_RX, PH_RD_HDR, PH_RD_RX, PH_POLL_CMD,
        PH_POLL_RX, PH_WEN, PH_PROG_HDR, PH_DATA_REQ, PH_DATA_TX
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] mosi;
        logic [7:0] rdata;
        logic       status;
    } res_t;

    typedef struct packed {
        logic [1:0]     cnt;
        res_t [2:0]     r;
    } bundle_t;

    function automatic res_t mk(kind_t k, logic [7:0] m, logic [7:0] d, logic s);
        res_t x;
        x.kind   = k;
        x.mosi   = m;
        x.rdata  = d;
        x.status = s;
        return x;
    endfunction

endpackage

// ===== rtl/snfcs_front.sv =====
module snfcs_front import snfcs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    input  logic [2:0]  in_action,
    input  logic [23:0] in_address,
    input  logic [15:0] in_length,
    input  logic [7:0]  in_miso,
    input  logic        in_berr,
    input  logic [7:0]  in_data,
    output logic        push,
    output bundle_t     push_bundle
);

    phase_t                  phase_reg, phase_next;
    op_t                     op_reg, op_next;
    logic [ADDRESS_BITS-1:0] cur_reg, cur_next;
    logic [15:0]             rem_reg, rem_next;
    logic [PAGE_BITS:0]      pg_reg, pg_next;
    logic [2:0]              step_reg, step_next;
    logic [15:0]             el_reg, el_next;
    logic [7:0]              id_reg, id_next;
    logic                    post_reg, post_next;
    logic [15:0]             tmo_reg;

    logic [23:0]             cur_x;
    logic [ADDRESS_BITS-1:0] addr_in;
    logic [1:0]              cnt;
    bundle_t                 b;
    logic [7:0]              hdr;
    logic [7:0]              opc;

    function automatic logic [PAGE_BITS:0] page_fill(logic [ADDRESS_BITS-1:0] c,
                                                     logic [15:0] r);
        logic [PAGE_BITS:0] room;
        room = (PAGE_BITS+1)'(PAGE_BYTES) - {1'b0, c[PAGE_BITS-1:0]};
        if (r < 16'(room)) return r[PAGE_BITS:0];
        return room;
    endfunction

    assign cur_x   = 24'(cur_reg);
    assign addr_in = in_address[ADDRESS_BITS-1:0];
    assign opc     = (op_reg == OP_ERASE) ? CMD_SE : CMD_PP;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tmo_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            tmo_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            op_reg    <= OP_PROBE;
            cur_reg   <= '0;
            rem_reg   <= '0;
            pg_reg    <= '0;
            step_reg  <= '0;
            el_reg    <= '0;
            id_reg    <= '0;
            post_reg  <= 1'b0;
        end else if (in_valid) begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            cur_reg   <= cur_next;
            rem_reg   <= rem_next;
            pg_reg    <= pg_next;
            step_reg  <= step_next;
            el_reg    <= el_next;
            id_reg    <= id_next;
            post_reg  <= post_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        op_next    = op_reg;
        cur_next   = cur_reg;
        rem_next   = rem_reg;
        pg_next    = pg_reg;
        step_next  = step_reg;
        el_next    = el_reg;
        id_next    = id_reg;
        post_next  = post_reg;
        b          = '0;
        cnt        = '0;
        hdr        = BYTE_ZERO;
        case (in_action)
            ACT_PROBE, ACT_READ, ACT_ERASE, ACT_WRITE: begin
                if (phase_reg == PH_IDLE) begin
                    op_next   = op_t'(in_action[1:0]);
                    cur_next  = addr_in;
                    rem_next  = in_length;
                    step_next = '0;
                    el_next   = '0;
                    if (in_action == ACT_PROBE) begin
                        b.r[cnt] = mk(K_SPI, CMD_RDID, BYTE_ZERO, 1'b0); cnt = cnt + 2'd1;
                        phase_next = PH_ID_CMD;
                    end else if (in_action == ACT_ERASE) begin
                        post_next = 1'b0;
                        b.r[cnt] = mk(K_SPI, CMD_RDSR, BYTE_ZERO, 1'b0); cnt = cnt + 2'd1;
                        phase_next = PH_POLL_CMD;
                    end else if (in_length == 16'd0) begin
                        b.r[cnt] = mk(K_DONE, BYTE_ZERO, BYTE_ZERO, 1'b0); cnt = cnt + 2'd1;
                        phase_next = PH_IDLE;
                    end else if (in_action == ACT_READ) begin
                        b.r[cnt] = mk(K_SPI, CMD_READ, BYTE_ZERO, 1'b0); cnt = cnt + 2'd1;
                        phase_next = PH_RD_HDR;
                    end else begin
                        pg_next   = page_fill(addr_in, in_length);
                        post_next = 1'b0;
                        b.r[cnt] = mk(K_SPI, CMD_RDSR, BYTE_ZERO, 1'b0); cnt = cnt + 2'd1;
                        phase_next = PH_POLL_CMD;
                    end
                end
            end
            ACT_BYTE: begin
                if (phase_reg != PH_IDLE && phase_reg != PH_DATA_REQ) begin
                    if (in_berr) begin
                        b.r[cnt] = mk(K_CS, BYTE_ZERO, BYTE_ZERO, 1'b0); cnt = cnt + 2'd1;
                        b.r[cnt] = mk(K_DONE, BYTE_ZERO, BYTE_ZERO, 1'b1); cnt = cnt + 2'd1;
                        phase_next = PH_IDLE;
                    end else begin
                        unique case (phase_reg)
                            PH_ID_CMD: begin
                                step_next = '0;
                                b.r[cnt] = mk(K_SPI, BYTE_ZERO, BYTE_ZERO, 1'b0);
                                cnt = cnt + 2'd1;
                                phase_next = PH_ID_RX;
                            end
                            PH_ID_RX: begin
                                if (step_reg == 3'd0) id_next = in_miso;
                                step_next = step_reg + 3'd1;
                                if (step_next < 3'd3) begin
                                    b.r[cnt] = mk(K_SPI, BYTE_ZERO, BYTE_ZERO, 1'b0);
                                    cnt = cnt + 2'd1;
                                end else begin
                                    b.r[cnt] = mk(K_CS, BYTE_ZERO, BYTE_ZERO, 1'b0);
                                    cnt = cnt + 2'd1;
                                    b.r[cnt] = mk(K_DONE, BYTE_ZERO, BYTE_ZERO,
                                        (id_next == BYTE_ZERO) || (id_next == BYTE_ONES));
                                    cnt = cnt + 2'd1;
                                    phase_next = PH_IDLE;
                                end
                            end
                            PH_RD_HDR: begin
                                step_next = step_reg + 3'd1;
                                if (step_next < 3'd4) begin
                                    unique case (step_next)
                                        3'd1:    hdr = cur_x[23:16];
                                        3'd2:    hdr = cur_x[15:8];
                                        default: hdr = cur_x[7:0];
                                    endcase
                                    b.r[cnt] = mk(K_SPI, hdr, BYTE_ZERO, 1'b0);
                                    cnt = cnt + 2'd1;
                                end else begin
                                    b.r[cnt] = mk(K_SPI, BYTE_ZERO, BYTE_ZERO, 1'b0);
                                    cnt = cnt + 2'd1;
                                    phase_next = PH_RD_RX;
                                end
                            end
                            PH_RD_RX: begin
                                b.r[cnt] = mk(K_RBYTE, BYTE_ZERO, in_miso, 1'b0);
                                cnt = cnt + 2'd1;
                                rem_next = rem_reg - 16'd1;
                                cur_next = cur_reg + ADDRESS_BITS'(1);
                                if (rem_next == 16'd0) begin
                                    b.r[cnt] = mk(K_CS, BYTE_ZERO, BYTE_ZERO, 1'b0);
                                    cnt = cnt + 2'd1;
                                    b.r[cnt] = mk(K_DONE, BYTE_ZERO, BYTE_ZERO, 1'b0);
                                    cnt = cnt + 2'd1;
                                    phase_next = PH_IDLE;
                                end else begin
                                    b.r[cnt] = mk(K_SPI, BYTE_ZERO, BYTE_ZERO, 1'b0);
                                    cnt = cnt + 2'd1;
                                end
                            end
                            PH_POLL_CMD: begin
                                b.r[cnt] = mk(K_SPI, BYTE_ZERO, BYTE_ZERO, 1'b0);
                                cnt = cnt + 2'd1;
                                phase_next = PH_POLL_RX;
                            end
                            PH_POLL_RX: begin
                                b.r[cnt] = mk(K_CS, BYTE_ZERO, BYTE_ZERO, 1'b0);
                                cnt = cnt + 2'd1;
                                if (!in_miso[0]) begin
                                    if (!post_reg) begin
                                        b.r[cnt] = mk(K_SPI, CMD_WREN, BYTE_ZERO, 1'b0);
                                        cnt = cnt + 2'd1;
                                        phase_next = PH_WEN;
                                    end else if (op_reg == OP_WRITE && rem_reg != 16'd0) begin
                                        pg_next   = page_fill(cur_reg, rem_reg);
                                        post_next = 1'b0;
                                        el_next   = '0;
                                        b.r[cnt] = mk(K_SPI, CMD_RDSR, BYTE_ZERO, 1'b0);
                                        cnt = cnt + 2'd1;
                                        phase_next = PH_POLL_CMD;
                                    end else begin
                                        b.r[cnt] = mk(K_DONE, BYTE_ZERO, BYTE_ZERO, 1'b0);
                                        cnt = cnt + 2'd1;
                                        phase_next = PH_IDLE;
                                    end
                                end else if (el_reg > tmo_reg) begin
                                    b.r[cnt] = mk(K_DONE, BYTE_ZERO, BYTE_ZERO, 1'b1);
                                    cnt = cnt + 2'd1;
                                    phase_next = PH_IDLE;
                                end else begin
                                    b.r[cnt] = mk(K_SPI, CMD_RDSR, BYTE_ZERO, 1'b0);
                                    cnt = cnt + 2'd1;
                                    phase_next = PH_POLL_CMD;
                                end
                            end
                            PH_WEN: begin
                                b.r[cnt] = mk(K_CS, BYTE_ZERO, BYTE_ZERO, 1'b0);
                                cnt = cnt + 2'd1;
                                step_next = '0;
                                b.r[cnt] = mk(K_SPI, opc, BYTE_ZERO, 1'b0);
                                cnt = cnt + 2'd1;
                                phase_next = PH_PROG_HDR;
                            end
                            PH_PROG_HDR: begin
                                step_next = step_reg + 3'd1;
                                if (step_next < 3'd4) begin
                                    unique case (step_next)
                                        3'd1:    hdr = cur_x[23:16];
                                        3'd2:    hdr = cur_x[15:8];
                                        default: hdr = cur_x[7:0];
                                    endcase
                                    b.r[cnt] = mk(K_SPI, hdr, BYTE_ZERO, 1'b0);
                                    cnt = cnt + 2'd1;
                                end else if (op_reg == OP_WRITE && pg_reg != '0) begin
                                    b.r[cnt] = mk(K_REQ, BYTE_ZERO, BYTE_ZERO, 1'b0);
                                    cnt = cnt + 2'd1;
                                    phase_next = PH_DATA_REQ;
                                end else begin
                                    b.r[cnt] = mk(K_CS, BYTE_ZERO, BYTE_ZERO, 1'b0);
                                    cnt = cnt + 2'd1;
                                    post_next = 1'b1;
                                    el_next   = '0;
                                    b.r[cnt] = mk(K_SPI, CMD_RDSR, BYTE_ZERO, 1'b0);
                                    cnt = cnt + 2'd1;
                                    phase_next = PH_POLL_CMD;
                                end
                            end
                            PH_DATA_TX: begin
                                pg_next  = pg_reg - (PAGE_BITS+1)'(1);
                                rem_next = rem_reg - 16'd1;
                                cur_next = cur_reg + ADDRESS_BITS'(1);
                                if (pg_next != '0 && rem_next != 16'd0) begin
                                    b.r[cnt] = mk(K_REQ, BYTE_ZERO, BYTE_ZERO, 1'b0);
                                    cnt = cnt + 2'd1;
                                    phase_next = PH_DATA_REQ;
                                end else begin
                                    pg_next = '0;
                                    b.r[cnt] = mk(K_CS, BYTE_ZERO, BYTE_ZERO, 1'b0);
                                    cnt = cnt + 2'd1;
                                    post_next = 1'b1;
                                    el_next   = '0;
                                    b.r[cnt] = mk(K_SPI, CMD_RDSR, BYTE_ZERO, 1'b0);
                                    cnt = cnt + 2'd1;
                                    phase_next = PH_POLL_CMD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ACT_DATA: begin
                if (phase_reg == PH_DATA_REQ) begin
                    b.r[cnt] = mk(K_SPI, in_data, BYTE_ZERO, 1'b0); cnt = cnt + 2'd1;
                    phase_next = PH_DATA_TX;
                end
            end
            ACT_TICK: begin
                if (phase_reg != PH_IDLE && el_reg != 16'hFFFF) el_next = el_reg + 16'd1;
            end
            default: ;
        endcase
        b.cnt = cnt;
    end

    assign push        = in_valid && (cnt != 2'd0);
    assign push_bundle = b;

endmodule

// ===== rtl/snfcs_fifo.sv =====
module snfcs_fifo import snfcs_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    wr_en,
    input  bundle_t wr_data,
    output logic    full,
    input  logic    rd_en,
    output logic    empty,
    output bundle_t rd_data
);

    bundle_t              mem [QDEPTH];
    logic [QPTR_BITS-1:0] wp_reg, rp_reg;
    logic [QPTR_BITS:0]   cnt_reg, cnt_next;

    assign full    = (cnt_reg == (QPTR_BITS+1)'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem[rp_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en) cnt_next = cnt_reg + (QPTR_BITS+1)'(1);
        if (!wr_en && rd_en) cnt_next = cnt_reg - (QPTR_BITS+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + QPTR_BITS'(1);
            if (rd_en) rp_reg <= rp_reg + QPTR_BITS'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/snfcs_back.sv =====
module snfcs_back import snfcs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  bundle_t     q_data,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic [1:0] idx_reg;
    res_t       cur;
    logic       fin;

    assign cur      = q_data.r[idx_reg];
    assign fin      = (idx_reg + 2'd1 == q_data.cnt);
    assign m_tvalid = !q_empty;
    assign m_tdata  = {7'd0, cur.status, cur.rdata, cur.mosi};
    assign m_tuser  = cur.kind;
    assign m_tlast  = fin;
    assign q_pop    = m_tvalid && m_tready && fin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            idx_reg <= fin ? 2'd0 : idx_reg + 2'd1;
        end
    end

endmodule

// ===== rtl/spi_nor_flash_command_sequencer_unit.sv =====
// SPI NOR command sequencer. One input word is taken per clock while the
// result queue (4 entries, one per input word that yields results) has room;
// each word yields 0 to 3 result words, which leave one per clock while
// m_tready is high, so the sustained rate is set by the result port. Busy
// timeout resets to 5000.
module spi_nor_flash_command_sequencer_unit import snfcs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // address, length, miso_byte, bus_error, data_byte
    input  logic [2:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // mosi_byte, read_data, status
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast
);

    logic    full, empty, push, pop;
    bundle_t wb, rb;

    assign s_tready = !full;

    snfcs_front u_front (
        .aclk, .aresetn, .cfg_we, .cfg_wdata,
        .in_valid   (s_tvalid && s_tready),
        .in_action  (s_tuser),
        .in_address (s_tdata[23:0]),
        .in_length  (s_tdata[39:24]),
        .in_miso    (s_tdata[47:40]),
        .in_berr    (s_tdata[48]),
        .in_data    (s_tdata[56:49]),
        .push       (push),
        .push_bundle(wb)
    );

    snfcs_fifo u_fifo (
        .aclk, .aresetn,
        .wr_en(push), .wr_data(wb), .full(full),
        .rd_en(pop), .empty(empty), .rd_data(rb)
    );

    snfcs_back u_back (
        .aclk, .aresetn,
        .q_empty(empty), .q_data(rb), .q_pop(pop),
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );

endmodule

// ===== rtl/snfcs_checker.sv =====
module snfcs_checker import snfcs_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    a_rst_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled word changed");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == K_DONE |-> m_tlast)
        else $error("done word not last");

    a_rdata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != K_RBYTE |-> m_tdata[15:8] == 8'd0)
        else $error("read data on non-read word");

endmodule

bind spi_nor_flash_command_sequencer_unit snfcs_checker u_chk (.*);
